// ----- hdl/bounded_deque_with_odd_filter_macros.svh -----
// ----------------------------------------------------------------------------
// Bounded deque assertion macros
// Shared concurrent assertion forms for the deque block.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_DEQUE_WITH_ODD_FILTER_MACROS_SVH
`define BOUNDED_DEQUE_WITH_ODD_FILTER_MACROS_SVH

// same-cycle implication
`define BDQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BDQ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/bdq_pkg.sv -----
// ----------------------------------------------------------------------------
// Bounded deque package
// Sizes, request and status codes, command type and ring index helpers.
// ----------------------------------------------------------------------------
package bdq_pkg;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned IDX_W      = $clog2(DEPTH);
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned REQ_W      = 3;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned OCC_W      = 5;
  localparam int unsigned CMDQ_DEPTH = 2;
  localparam int unsigned CMDQ_AW    = $clog2(CMDQ_DEPTH);
  localparam int unsigned CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic signed [DATA_W-1:0] data_t;

  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = REQ_W'(0);
  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = REQ_W'(1);
  localparam logic [REQ_W-1:0] REQ_FILTER     = REQ_W'(2);
  localparam logic [REQ_W-1:0] REQ_DUMP_FWD   = REQ_W'(3);
  localparam logic [REQ_W-1:0] REQ_DUMP_BWD   = REQ_W'(4);
  localparam logic [REQ_W-1:0] REQ_CLEAR      = REQ_W'(5);

  localparam logic [STATUS_W-1:0] ST_OK    = STATUS_W'(0);
  localparam logic [STATUS_W-1:0] ST_FULL  = STATUS_W'(1);
  localparam logic [STATUS_W-1:0] ST_EMPTY = STATUS_W'(2);

  typedef enum logic [2:0] {
    OP_PUSH_FRONT,
    OP_PUSH_BACK,
    OP_FILTER,
    OP_DUMP_FWD,
    OP_DUMP_BWD,
    OP_CLEAR,
    OP_NOP
  } op_e;

  typedef struct packed {
    op_e   op;
    data_t value;
  } cmd_t;

  function automatic idx_t idx_inc(idx_t i);
    return (i == idx_t'(DEPTH - 1)) ? '0 : idx_t'(i + idx_t'(1));
  endfunction

  function automatic idx_t idx_dec(idx_t i);
    return (i == '0) ? idx_t'(DEPTH - 1) : idx_t'(i - idx_t'(1));
  endfunction

endpackage

// ----- hdl/bdq_req_if.sv -----
// ----------------------------------------------------------------------------
// Deque request channel
// Valid/ready channel that carries one request item.
// ----------------------------------------------------------------------------
interface bdq_req_if import bdq_pkg::*; ();

  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] req_type;
  data_t            value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink   (input valid, input req_type, input value, output ready);

endinterface

// ----- hdl/bdq_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Deque result channel
// Valid/ready channel that carries one result item.
// ----------------------------------------------------------------------------
interface bdq_rsp_if import bdq_pkg::*; ();

  logic                valid;
  logic                ready;
  data_t               data;
  logic                last;
  logic [STATUS_W-1:0] status;
  logic [OCC_W-1:0]    occupancy;

  modport source (output valid, output data, output last, output status,
                  output occupancy, input ready);
  modport sink   (input valid, input data, input last, input status,
                  input occupancy, output ready);

endinterface

// ----- hdl/bdq_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bdq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/bdq_front.sv -----
// ----------------------------------------------------------------------------
// Deque front end
// Accept request items, decode them into commands and queue them.
// ----------------------------------------------------------------------------
module bdq_front import bdq_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  bdq_req_if.sink       req_i,
  output logic          cmd_valid_o,
  output cmd_t          cmd_o,
  input  logic          cmd_ready_i
);

  cmd_t               slot_q [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_q, wr_d;
  logic [CMDQ_AW-1:0] rd_q, rd_d;
  logic [CMDQ_CW-1:0] fill_q, fill_d;
  cmd_t               cmd_new;
  logic               push;
  logic               pop;

  function automatic logic [CMDQ_AW-1:0] qptr_inc(logic [CMDQ_AW-1:0] p);
    return (p == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : CMDQ_AW'(p + 1'b1);
  endfunction

  always_comb begin
    cmd_new.value = req_i.value;
    unique case (req_i.req_type)
      REQ_PUSH_FRONT: cmd_new.op = OP_PUSH_FRONT;
      REQ_PUSH_BACK:  cmd_new.op = OP_PUSH_BACK;
      REQ_FILTER:     cmd_new.op = OP_FILTER;
      REQ_DUMP_FWD:   cmd_new.op = OP_DUMP_FWD;
      REQ_DUMP_BWD:   cmd_new.op = OP_DUMP_BWD;
      REQ_CLEAR:      cmd_new.op = OP_CLEAR;
      default:        cmd_new.op = OP_NOP;
    endcase
  end

  assign req_i.ready = (fill_q != CMDQ_CW'(CMDQ_DEPTH));
  assign push        = req_i.valid && req_i.ready;
  assign cmd_valid_o = (fill_q != '0);
  assign cmd_o       = slot_q[rd_q];
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_d   = push ? qptr_inc(wr_q) : wr_q;
    rd_d   = pop ? qptr_inc(rd_q) : rd_q;
    fill_d = fill_q;
    if (push && !pop) begin
      fill_d = CMDQ_CW'(fill_q + 1'b1);
    end else if (pop && !push) begin
      fill_d = CMDQ_CW'(fill_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= cmd_new;
    end
  end

endmodule

// ----- hdl/bdq_back.sv -----
// ----------------------------------------------------------------------------
// Deque back end
// Execute queued commands on the ring store and register each result.
// ----------------------------------------------------------------------------
module bdq_back import bdq_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  cmd_t          cmd_i,
  output logic          cmd_ready_o,
  bdq_rsp_if.source     rsp_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DUMP,
    S_FILT,
    S_FILT_END
  } state_e;

  state_e              state_q, state_d;
  idx_t                head_q, head_d;
  idx_t                tail_q, tail_d;
  cnt_t                count_q, count_d;
  idx_t                ptr_q, ptr_d;
  idx_t                wptr_q, wptr_d;
  cnt_t                left_q, left_d;
  cnt_t                kept_q, kept_d;
  logic                fwd_q, fwd_d;
  logic                out_valid_q, out_valid_d;
  data_t               out_data_q, out_data_d;
  logic                out_last_q, out_last_d;
  logic [STATUS_W-1:0] out_status_q, out_status_d;
  logic [OCC_W-1:0]    out_occ_q, out_occ_d;

  logic                out_free;
  logic                emit;
  data_t               e_data;
  logic                e_last;
  logic [STATUS_W-1:0] e_status;
  logic [OCC_W-1:0]    e_occ;
  logic                ram_we;
  idx_t                ram_waddr;
  logic [DATA_W-1:0]   ram_wdata;
  logic                ram_re;
  idx_t                ram_raddr;
  logic [DATA_W-1:0]   ram_rdata;
  idx_t                slot;

  bdq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_free = !out_valid_q || rsp_o.ready;

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    ptr_d       = ptr_q;
    wptr_d      = wptr_q;
    left_d      = left_q;
    kept_d      = kept_q;
    fwd_d       = fwd_q;
    cmd_ready_o = 1'b0;
    emit        = 1'b0;
    e_data      = '0;
    e_last      = 1'b1;
    e_status    = ST_OK;
    e_occ       = OCC_W'(count_q);
    ram_we      = 1'b0;
    ram_waddr   = wptr_q;
    ram_wdata   = ram_rdata;
    ram_re      = 1'b0;
    ram_raddr   = ptr_q;
    slot        = idx_dec(head_q);

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && out_free) begin
          cmd_ready_o = 1'b1;
          unique case (cmd_i.op) inside
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
              emit = 1'b1;
              if (count_q == cnt_t'(DEPTH)) begin
                e_status = ST_FULL;
              end else begin
                slot = (cmd_i.op == OP_PUSH_FRONT) ? idx_dec(head_q) : tail_q;
                ram_we    = 1'b1;
                ram_waddr = slot;
                ram_wdata = cmd_i.value;
                if (cmd_i.op == OP_PUSH_FRONT) begin
                  head_d = slot;
                end else begin
                  tail_d = idx_inc(tail_q);
                end
                count_d = cnt_t'(count_q + 1'b1);
                e_occ   = OCC_W'(count_d);
              end
            end
            OP_DUMP_FWD, OP_DUMP_BWD: begin
              if (count_q == '0) begin
                emit     = 1'b1;
                e_status = ST_EMPTY;
                e_occ    = '0;
              end else begin
                fwd_d     = (cmd_i.op == OP_DUMP_FWD);
                ram_re    = 1'b1;
                ram_raddr = fwd_d ? head_q : idx_dec(tail_q);
                ptr_d     = fwd_d ? idx_inc(ram_raddr) : idx_dec(ram_raddr);
                left_d    = count_q;
                state_d   = S_DUMP;
              end
            end
            OP_FILTER: begin
              if (count_q == '0) begin
                emit   = 1'b1;
                tail_d = head_q;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = head_q;
                ptr_d     = idx_inc(head_q);
                wptr_d    = head_q;
                left_d    = count_q;
                kept_d    = '0;
                state_d   = S_FILT;
              end
            end
            OP_CLEAR: begin
              emit    = 1'b1;
              head_d  = '0;
              tail_d  = '0;
              count_d = '0;
              e_occ   = '0;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      S_DUMP: begin
        if (out_free) begin
          emit   = 1'b1;
          e_data = data_t'(ram_rdata);
          e_last = (left_q == cnt_t'(1));
          left_d = cnt_t'(left_q - 1'b1);
          if (left_q == cnt_t'(1)) begin
            state_d = S_IDLE;
          end else begin
            ram_re = 1'b1;
            ptr_d  = fwd_q ? idx_inc(ptr_q) : idx_dec(ptr_q);
          end
        end
      end
      S_FILT: begin
        left_d = cnt_t'(left_q - 1'b1);
        if (!ram_rdata[0]) begin
          ram_we = 1'b1;
          wptr_d = idx_inc(wptr_q);
          kept_d = cnt_t'(kept_q + 1'b1);
        end
        if (left_q == cnt_t'(1)) begin
          count_d = kept_d;
          tail_d  = wptr_d;
          state_d = S_FILT_END;
        end else begin
          ram_re = 1'b1;
          ptr_d  = idx_inc(ptr_q);
        end
      end
      S_FILT_END: begin
        if (out_free) begin
          emit    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    out_last_d   = out_last_q;
    out_status_d = out_status_q;
    out_occ_d    = out_occ_q;
    if (emit) begin
      out_valid_d  = 1'b1;
      out_data_d   = e_data;
      out_last_d   = e_last;
      out_status_d = e_status;
      out_occ_d    = e_occ;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      head_q       <= '0;
      tail_q       <= '0;
      count_q      <= '0;
      ptr_q        <= '0;
      wptr_q       <= '0;
      left_q       <= '0;
      kept_q       <= '0;
      fwd_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      out_data_q   <= '0;
      out_last_q   <= 1'b0;
      out_status_q <= ST_OK;
      out_occ_q    <= '0;
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      tail_q       <= tail_d;
      count_q      <= count_d;
      ptr_q        <= ptr_d;
      wptr_q       <= wptr_d;
      left_q       <= left_d;
      kept_q       <= kept_d;
      fwd_q        <= fwd_d;
      out_valid_q  <= out_valid_d;
      out_data_q   <= out_data_d;
      out_last_q   <= out_last_d;
      out_status_q <= out_status_d;
      out_occ_q    <= out_occ_d;
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.data      = out_data_q;
  assign rsp_o.last      = out_last_q;
  assign rsp_o.status    = out_status_q;
  assign rsp_o.occupancy = out_occ_q;

endmodule

// ----- hdl/bounded_deque_with_odd_filter.sv -----
// ----------------------------------------------------------------------------
// Bounded deque with odd filter
// Double-ended queue of signed words in a ring store, with in-place removal
// of odd values and front-to-back or back-to-front readout.
// ----------------------------------------------------------------------------
// Requests enter a two-entry command queue and are executed one at a time by
// the back end, which owns the single-port-pair ring store and a result
// register. Push, clear and unused codes retire one per cycle while the result
// side accepts, so a stream of them is then taken at one item per cycle. A
// readout first starts a store read, then gives one result per cycle while
// the result side accepts; an empty readout gives a single empty status. An
// odd-value removal walks the held entries one per cycle through the store's
// read port, compacting kept values through the write port, then issues its
// status once the result side is free; on an empty deque it only issues its
// status. The store needs no clearing pass after reset.
`include "bounded_deque_with_odd_filter_macros.svh"

module bounded_deque_with_odd_filter import bdq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  bdq_req_if.sink   req_i,
  bdq_rsp_if.source rsp_o
);

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;
  logic is_full;
  logic full_ok;
  logic is_empty;
  logic empty_ok;
  logic mid_beat;

  bdq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_ready_i (cmd_ready)
  );

  bdq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_ready_o (cmd_ready),
    .rsp_o       (rsp_o)
  );

  assign is_full  = rsp_o.valid && (rsp_o.status == ST_FULL);
  assign full_ok  = (rsp_o.occupancy == OCC_W'(DEPTH)) && rsp_o.last;
  assign is_empty = rsp_o.valid && (rsp_o.status == ST_EMPTY);
  assign empty_ok = (rsp_o.occupancy == '0) && (rsp_o.data == '0) && rsp_o.last;
  assign mid_beat = rsp_o.valid && rsp_o.ready && !rsp_o.last;

  `BDQ_ASSERT_IMP(a_full_occ, clk_i, rst_ni, is_full, full_ok, "full result malformed")
  `BDQ_ASSERT_IMP(a_empty_res, clk_i, rst_ni, is_empty, empty_ok, "malformed empty result")
  `BDQ_ASSERT_NXT(a_dump_burst, clk_i, rst_ni, mid_beat, rsp_o.valid, "gap inside a readout")

endmodule
